// File: design/tdtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdtd_pkg
// Shared widths, register indexes, reset values and result type for the
// touch debounce / tap detector.
// ----------------------------------------------------------------------------
package tdtd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STABLE_W   = 16;
  localparam int HELD_W     = 24;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 16'd35;
  localparam logic [CFG_DATA_W-1:0] GRACE_RST    = 16'd120;
  localparam logic [CFG_DATA_W-1:0] TAP_MAX_RST  = 16'd2000;

  localparam logic [STABLE_W-1:0] STABLE_MAX = {STABLE_W{1'b1}};
  localparam logic [HELD_W-1:0]   HELD_MAX   = {HELD_W{1'b1}};

  typedef struct packed {
    logic              pressed;
    logic              tapped;
    logic [HELD_W-1:0] held_ms;
  } result_t;

endpackage

// File: design/touch_debounce_tap_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_debounce_tap_detector_unit
// Millisecond-tick debouncer for one touch line with tap detection.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the raw touch level
// and a take-tap request; each tick yields exactly one result transfer with
// the debounced pressed state, the tap flag (before the take clears it) and
// the time held. A tick is accepted every cycle unless stalled: the whole
// state update is one pass of counter increments, one 16-bit threshold compare
// pair and one TIME_BITS-wide subtract/compare against tap_max, ending in the
// state and result registers. Results sit in an output register backed by a
// one-entry skid register, so the input keeps flowing for one tick after the
// output stalls; in_stall_o is simply "skid entry full". Configuration
// writes are always ready and must only happen while no ticks are in flight.
// ----------------------------------------------------------------------------
module touch_debounce_tap_detector_unit
  import tdtd_pkg::*;
#(
  parameter int TIME_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tick input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  touch_level_i,
  input  logic                  take_tap_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  pressed_o,
  output logic                  tapped_o,
  output logic [HELD_W-1:0]     held_ms_o,
  // config write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  // common width for comparing press time with the held clip level
  localparam int WIDE_W = (TIME_BITS > HELD_W) ? TIME_BITS : HELD_W;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] debounce_q, grace_q, tap_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      grace_q    <= GRACE_RST;
      tap_max_q  <= TAP_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_GRACE:    grace_q    <= cfg_data_i;
        CFG_TAP_MAX:  tap_max_q  <= cfg_data_i;
        default:      ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Debounce state
  // --------------------------------------------------------------------------
  logic                 raw_q, raw_d;
  logic                 deb_q, deb_d;
  logic [STABLE_W-1:0]  stable_q, stable_d;
  logic                 active_q, active_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic                 pend_q, pend_d;
  logic                 tap_q, tap_d;

  logic                 in_xfer;
  result_t              res;

  // scratch for the step
  logic                 raw_chg;
  logic [TIME_BITS-1:0] press_inc;
  logic [TIME_BITS-1:0] stable_ext;
  logic [TIME_BITS-1:0] dur;
  logic                 tap_upd;
  logic                 held_sat;

  assign in_xfer = in_valid_i && !in_stall_o;

  always_comb begin
    raw_chg    = (touch_level_i != raw_q);
    raw_d      = touch_level_i;
    stable_d   = raw_chg ? '0 :
                 (stable_q != STABLE_MAX) ? stable_q + 1'b1 : stable_q;
    pend_d     = (raw_chg && touch_level_i) ? 1'b0 : pend_q;
    press_inc  = (deb_q && press_q != TIME_MAX) ? press_q + 1'b1 : press_q;
    press_d    = press_inc;
    deb_d      = deb_q;
    active_d   = active_q;
    tap_upd    = tap_q;
    stable_ext = TIME_BITS'(stable_d);
    dur        = (press_inc >= stable_ext) ? press_inc - stable_ext : '0;

    if (touch_level_i != deb_q && stable_d >= debounce_q) begin
      if (touch_level_i) begin
        // press accepted, timed from the raw rising edge
        deb_d    = 1'b1;
        active_d = 1'b1;
        press_d  = stable_ext;
        pend_d   = 1'b0;
        tap_upd  = 1'b0;
      end else begin
        pend_d = 1'b1;
        if (stable_d >= grace_q) begin
          // release accepted; press length ends at the raw falling edge
          if (active_q && dur < TIME_BITS'(tap_max_q)) begin
            tap_upd = 1'b1;
          end
          deb_d    = 1'b0;
          active_d = 1'b0;
          press_d  = '0;
          pend_d   = 1'b0;
        end
      end
    end

    held_sat    = WIDE_W'(press_d) > WIDE_W'(HELD_MAX);
    res.pressed = deb_d;
    res.tapped  = tap_upd;
    res.held_ms = !(deb_d && active_d) ? '0 :
                  held_sat ? HELD_MAX : HELD_W'(press_d);
    tap_d       = take_tap_i ? 1'b0 : tap_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      deb_q    <= 1'b0;
      stable_q <= '0;
      active_q <= 1'b0;
      press_q  <= '0;
      pend_q   <= 1'b0;
      tap_q    <= 1'b0;
    end else if (in_xfer) begin
      raw_q    <= raw_d;
      deb_q    <= deb_d;
      stable_q <= stable_d;
      active_q <= active_d;
      press_q  <= press_d;
      pend_q   <= pend_d;
      tap_q    <= tap_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register plus skid entry
  // --------------------------------------------------------------------------
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_xfer;

  assign out_xfer   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !out_xfer) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !out_xfer) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pressed_o   = out_q.pressed;
  assign tapped_o    = out_q.tapped;
  assign held_ms_o   = out_q.held_ms;

endmodule

// File: verif/tdtd_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdtd_tick_checker
// Tracks debouncer state from observed ticks and register writes, predicts
// one report per tick and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module tdtd_tick_checker
  import tdtd_pkg::*;
#(
  parameter int TIME_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  touch_level_i,
  input  logic                  take_tap_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  pressed_i,
  input  logic                  tapped_i,
  input  logic [HELD_W-1:0]     held_ms_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam logic [TIME_BITS-1:0] PRESS_MAX = {TIME_BITS{1'b1}};

  logic [CFG_DATA_W-1:0] debounce_ms;
  logic [CFG_DATA_W-1:0] grace_ms;
  logic [CFG_DATA_W-1:0] tap_max_ms;

  logic                 raw_lvl;
  logic                 deb_lvl;
  logic                 press_on;
  logic                 release_wait;
  logic                 tap_flag;
  logic [STABLE_W-1:0]  stable_ms;
  logic [TIME_BITS-1:0] press_ms;

  result_t tick_report_q[$];

  // one millisecond of debouncer behavior; returns the report for the tick
  function automatic result_t advance_tick(input logic lvl, input logic take);
    result_t              rep;
    logic [TIME_BITS-1:0] dur;
    if (lvl != raw_lvl) begin
      raw_lvl   = lvl;
      stable_ms = '0;
      if (lvl) release_wait = 1'b0;
    end else if (stable_ms != STABLE_MAX) begin
      stable_ms = stable_ms + 1'b1;
    end

    if (deb_lvl && press_ms != PRESS_MAX) press_ms = press_ms + 1'b1;

    if (raw_lvl != deb_lvl && stable_ms >= debounce_ms) begin
      if (raw_lvl) begin
        deb_lvl      = 1'b1;
        press_on     = 1'b1;
        press_ms     = TIME_BITS'(stable_ms);
        release_wait = 1'b0;
        tap_flag     = 1'b0;
      end else begin
        release_wait = 1'b1;
        if (stable_ms >= grace_ms) begin
          if (press_on) begin
            // press length runs from raw rise to raw fall
            dur = (press_ms >= TIME_BITS'(stable_ms)) ?
                  press_ms - TIME_BITS'(stable_ms) : '0;
            if (dur < TIME_BITS'(tap_max_ms)) tap_flag = 1'b1;
          end
          deb_lvl      = 1'b0;
          press_on     = 1'b0;
          press_ms     = '0;
          release_wait = 1'b0;
        end
      end
    end

    rep.pressed = deb_lvl;
    rep.tapped  = tap_flag;
    rep.held_ms = '0;
    if (deb_lvl && press_on) begin
      rep.held_ms = (32'(press_ms) > 32'(HELD_MAX)) ? HELD_MAX : HELD_W'(press_ms);
    end
    if (take) tap_flag = 1'b0;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      debounce_ms  = DEBOUNCE_RST;
      grace_ms     = GRACE_RST;
      tap_max_ms   = TAP_MAX_RST;
      raw_lvl      = 1'b0;
      deb_lvl      = 1'b0;
      press_on     = 1'b0;
      release_wait = 1'b0;
      tap_flag     = 1'b0;
      stable_ms    = '0;
      press_ms     = '0;
      tick_report_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.pressed = pressed_i;
        got.tapped  = tapped_i;
        got.held_ms = held_ms_i;
        if (tick_report_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with no tick outstanding: pressed=%0b tapped=%0b held=%0d",
                     $time, got.pressed, got.tapped, got.held_ms);
        end else begin
          want = tick_report_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: report mismatch: expected pressed=%0b tapped=%0b held=%0d,",
                        " got pressed=%0b tapped=%0b held=%0d"},
                       $time, want.pressed, want.tapped, want.held_ms,
                       got.pressed, got.tapped, got.held_ms);
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE: debounce_ms = cfg_data_i;
          CFG_GRACE:    grace_ms    = cfg_data_i;
          CFG_TAP_MAX:  tap_max_ms  = cfg_data_i;
          default:      ;
        endcase
      end

      if (in_valid_i && !in_stall_i)
        tick_report_q.push_back(advance_tick(touch_level_i, take_tap_i));
    end
    pending_o = tick_report_q.size();
  end

endmodule

// File: verif/tb_touch_debounce_tap_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_debounce_tap_detector_unit
// Drives millisecond ticks and register writes into the debouncer; a checker
// beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
// Flow: a quick press under the reset register values, a directed run with
// zero debounce (taps, take-tap clearing, glitch in the release grace, long
// press), then random phases of press/release runs sized around the current
// thresholds with single-tick noise, and finally a press held under maximum
// register values that only lands once the debounce is lowered, timed from
// the raw rising edge. Both sides idle at random; one stretch runs with no
// idling and opens with a long receiver hold-off so the block backs up into
// its input.
// ----------------------------------------------------------------------------
module tb_touch_debounce_tap_detector_unit;
  import tdtd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 60;   // long receiver hold-off
  localparam int CALM_TICKS      = 150;  // ticks with no idling on either side
  localparam int IDLE_PCT        = 38;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  touch_level_i = 1'b0;
  logic                  take_tap_i    = 1'b0;
  logic                  out_stall_i   = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic              pressed_o;
  logic              tapped_o;
  logic [HELD_W-1:0] held_ms_o;
  logic              cfg_ready_o;

  int fail_count;
  int pending;

  // shared between the stimulus and the receiver process
  bit calm;
  bit hold_req;
  bit hold_done;

  // current thresholds, used only to size the random runs
  logic [CFG_DATA_W-1:0] cur_deb   = DEBOUNCE_RST;
  logic [CFG_DATA_W-1:0] cur_grace = GRACE_RST;
  logic [CFG_DATA_W-1:0] cur_tap   = TAP_MAX_RST;
  logic                  line_lvl  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  touch_debounce_tap_detector_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .touch_level_i (touch_level_i),
    .take_tap_i    (take_tap_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pressed_o     (pressed_o),
    .tapped_o      (tapped_o),
    .held_ms_o     (held_ms_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tdtd_tick_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .touch_level_i (touch_level_i),
    .take_tap_i    (take_tap_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pressed_i     (pressed_o),
    .tapped_i      (tapped_o),
    .held_ms_i     (held_ms_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // One tick transfer. Random idle cycles ahead of it unless in a calm
  // stretch; returns in the step of the accepting edge.
  task automatic send_tick(input logic lvl, input logic take);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    touch_level_i <= lvl;
    take_tap_i    <= take;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    line_lvl = lvl;
  endtask

  task automatic send_run(input logic lvl, input int n_ticks, input logic take);
    repeat (n_ticks) send_tick(lvl, take);
  endtask

  // Wait until the checker has seen every outstanding report. Sampled on the
  // falling edge so the count is settled after the rising edge updates.
  task automatic drain();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Quiesce, then write all three registers back to back. Valid stays high
  // across the writes and drops once, after the last transfer.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] deb,
                              input logic [CFG_DATA_W-1:0] grace,
                              input logic [CFG_DATA_W-1:0] tap);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] vals [3];
    idx  = '{CFG_DEBOUNCE, CFG_GRACE, CFG_TAP_MAX};
    vals = '{deb, grace, tap};
    in_valid_i <= 1'b0;
    drain();
    repeat (4) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_deb   = deb;
    cur_grace = grace;
    cur_tap   = tap;
  endtask

  // Random phase: alternating press and release runs whose lengths straddle
  // the debounce, grace and tap thresholds, with single-tick noise mixed in.
  // At tick stretch_at the receiver is asked for its long hold-off and both
  // sides stop idling for a while (negative: never).
  task automatic run_phase(input int n_ticks, input int stretch_at);
    int   sent;
    int   seg_len;
    int   span;
    logic lvl;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(0, 99) < 15) begin
        lvl     = 1'($urandom_range(0, 1));
        seg_len = 1;
      end else begin
        lvl  = ~line_lvl;
        span = lvl ? int'(cur_deb) + int'(cur_tap) :
               ((cur_deb > cur_grace) ? int'(cur_deb) : int'(cur_grace));
        if (span > 300) span = 300;
        seg_len = int'($urandom_range(1, span + 4));
      end
      repeat (seg_len) begin
        if (sent < n_ticks) begin
          if (sent == stretch_at) begin
            calm     = 1'b1;
            hold_req = 1'b1;
          end
          if (sent == stretch_at + CALM_TICKS) calm = 1'b0;
          send_tick(lvl, $urandom_range(0, 3) == 0);
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request, none while calm.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // press long enough for the reset debounce value
    send_run(1'b1, 40, 1'b0);
    send_run(1'b0, 2, 1'b1);

    // directed: zero debounce, short grace, small tap window
    program_regs(16'd0, 16'd2, 16'd3);
    send_run(1'b0, 1, 1'b0);   // grace met, pending release lands
    send_run(1'b1, 1, 1'b0);   // press taken on the tick it appears
    send_run(1'b0, 3, 1'b0);   // short press -> tap
    send_run(1'b0, 1, 1'b1);   // tap reported, then cleared
    send_run(1'b0, 1, 1'b0);
    send_run(1'b1, 1, 1'b0);
    send_run(1'b0, 1, 1'b0);   // release starts pending
    send_run(1'b1, 1, 1'b0);   // glitch in the grace window cancels it
    send_run(1'b0, 3, 1'b0);
    send_run(1'b1, 6, 1'b0);   // long press, no tap
    send_run(1'b0, 3, 1'b0);
    send_run(1'b1, 2, 1'b1);

    // random phases across a spread of thresholds
    program_regs(16'd3, 16'd5, 16'd8);
    run_phase(250, -1);
    program_regs(16'd1, 16'd0, 16'd4);
    run_phase(200, -1);
    program_regs(16'd0, 16'd3, 16'd0);      // taps impossible
    run_phase(150, -1);
    program_regs(16'd6, 16'd10, 16'd20);
    run_phase(250, 100);                    // long hold-off lands here
    program_regs(16'd2, 16'd4, 16'hFFFF);
    run_phase(150, -1);
    program_regs(DEBOUNCE_RST, GRACE_RST, TAP_MAX_RST);
    run_phase(300, -1);

    // all registers at maximum: the press is held off, then lands as soon as
    // the debounce drops, timed from the raw rising edge; quick release
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_run(1'b1, 40, 1'b0);
    program_regs(16'd2, 16'd3, 16'hFFFF);
    send_run(1'b1, 2, 1'b0);
    send_run(1'b0, 6, 1'b0);
    send_run(1'b0, 2, 1'b1);

    in_valid_i <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_touch_debounce_tap_detector_unit: clean");
    end else begin
      $display("tb_touch_debounce_tap_detector_unit: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_touch_debounce_tap_detector_unit: errors");
    $finish;
  end

endmodule
